>>> rtl/core/sfcs_pkg.sv
// ============================================================================
// sfcs_pkg: shared types and constants for the SPI FRAM command sequencer
// Operation and status codes, FRAM opcodes and the header burst descriptor.
// ============================================================================
package sfcs_pkg;

  localparam int unsigned CAPACITY_BYTES_DEF = 131072;
  localparam int unsigned MAX_TRANSFER       = 256;
  localparam logic [15:0] TIMEOUT_RST        = 16'd10;

  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned COUNT_W = 9;

  localparam logic [7:0] OPC_WREN  = 8'h06;
  localparam logic [7:0] OPC_WRITE = 8'h02;
  localparam logic [7:0] OPC_READ  = 8'h03;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_DONE  = 2'd3
  } sfcs_op_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_PARAM     = 3'd1,
    ST_BUSY          = 3'd2,
    ST_WREN_TIMEOUT  = 3'd3,
    ST_WRITE_TIMEOUT = 3'd4,
    ST_READ_TIMEOUT  = 3'd5
  } sfcs_status_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'b0001,
    PH_WAIT_WREN  = 4'b0010,
    PH_WAIT_WRITE = 4'b0100,
    PH_WAIT_READ  = 4'b1000
  } sfcs_phase_t;

  // Emitter step: optional lead result, then four header bytes
  localparam logic [2:0] STEP_LEAD = 3'd0;
  localparam logic [2:0] STEP_CMD  = 3'd1;
  localparam logic [2:0] STEP_AHI  = 3'd2;
  localparam logic [2:0] STEP_AMID = 3'd3;
  localparam logic [2:0] STEP_ALO  = 3'd4;

  // Results caused by one request/event
  typedef struct packed {
    logic                lead_en;
    sfcs_status_t        lead_status;
    logic                lead_cs;
    logic                lead_valid;
    logic [7:0]          lead_byte;
    logic                lead_done;
    logic                hdr_en;
    logic [7:0]          hdr_cmd;
    logic [ADDR_W-1:0]   hdr_addr;
    logic [COUNT_W-1:0]  hdr_len;
  } sfcs_burst_t;

endpackage

>>> rtl/core/sfcs_emit.sv
// ============================================================================
// sfcs_emit: result burst emitter
// One-deep descriptor slot in front of the active burst; plays one result
// per cycle out of the active burst under valid/ready.
// ============================================================================
module sfcs_emit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      burst_valid,
  input  sfcs_pkg::sfcs_burst_t     burst,
  output logic                      burst_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                out_status,
  output logic                      out_chip_select,
  output logic                      out_byte_valid,
  output logic [7:0]                out_spi_byte,
  output logic [8:0]                out_payload_count,
  output logic                      out_transaction_done,
  output logic                      out_last
);

  sfcs_pkg::sfcs_burst_t slot_r, slot_nxt;
  logic                  slot_valid_r, slot_valid_nxt;
  sfcs_pkg::sfcs_burst_t cur_r, cur_nxt;
  logic                  cur_valid_r, cur_valid_nxt;
  logic [2:0]            step_r, step_nxt;

  logic [2:0] end_step;
  logic       take;
  logic       fin;
  logic       cur_free;

  function automatic logic [2:0] start_of(sfcs_pkg::sfcs_burst_t b);
    return b.lead_en ? sfcs_pkg::STEP_LEAD : sfcs_pkg::STEP_CMD;
  endfunction

  assign end_step    = cur_r.hdr_en ? sfcs_pkg::STEP_ALO : sfcs_pkg::STEP_LEAD;
  assign take        = cur_valid_r && out_ready;
  assign fin         = take && (step_r == end_step);
  assign cur_free    = !cur_valid_r || fin;
  assign burst_ready = !slot_valid_r;

  always_comb begin
    slot_nxt       = slot_r;
    slot_valid_nxt = slot_valid_r;
    cur_nxt        = cur_r;
    cur_valid_nxt  = cur_valid_r;
    step_nxt       = step_r;
    if (cur_free) begin
      if (slot_valid_r) begin
        cur_nxt        = slot_r;
        cur_valid_nxt  = 1'b1;
        step_nxt       = start_of(slot_r);
        slot_valid_nxt = 1'b0;
      end else if (burst_valid) begin
        // bypass the slot when the output side is free
        cur_nxt       = burst;
        cur_valid_nxt = 1'b1;
        step_nxt      = start_of(burst);
      end else begin
        cur_valid_nxt = 1'b0;
      end
    end else begin
      if (take) begin
        step_nxt = step_r + 3'd1;
      end
      if (burst_valid && burst_ready) begin
        slot_nxt       = burst;
        slot_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= 1'b0;
      cur_valid_r  <= 1'b0;
      step_r       <= sfcs_pkg::STEP_LEAD;
    end else begin
      slot_valid_r <= slot_valid_nxt;
      cur_valid_r  <= cur_valid_nxt;
      step_r       <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    cur_r  <= cur_nxt;
  end

  always_comb begin
    out_status           = sfcs_pkg::ST_OK;
    out_chip_select      = 1'b0;
    out_byte_valid       = 1'b1;
    out_spi_byte         = 8'h00;
    out_payload_count    = '0;
    out_transaction_done = 1'b0;
    unique case (step_r)
      sfcs_pkg::STEP_LEAD: begin
        out_status           = cur_r.lead_status;
        out_chip_select      = cur_r.lead_cs;
        out_byte_valid       = cur_r.lead_valid;
        out_spi_byte         = cur_r.lead_byte;
        out_transaction_done = cur_r.lead_done;
      end
      sfcs_pkg::STEP_CMD:  out_spi_byte = cur_r.hdr_cmd;
      sfcs_pkg::STEP_AHI:  out_spi_byte = cur_r.hdr_addr[23:16];
      sfcs_pkg::STEP_AMID: out_spi_byte = cur_r.hdr_addr[15:8];
      sfcs_pkg::STEP_ALO: begin
        out_spi_byte      = cur_r.hdr_addr[7:0];
        out_payload_count = cur_r.hdr_len;
      end
      default: out_byte_valid = 1'b0;
    endcase
  end

  assign out_valid = cur_valid_r;
  assign out_last  = (step_r == end_step);

  // pending slot only fills behind an active burst
  a_slot_behind_cur: assert property (@(posedge clk) disable iff (!rst_n)
    slot_valid_r |-> cur_valid_r)
    else $error("descriptor slot full with no active burst");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (step_r <= end_step))
    else $error("emitter step past end of burst");

  a_no_lead_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && !cur_r.lead_en) |-> (step_r != sfcs_pkg::STEP_LEAD))
    else $error("emitting an absent lead result");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && !out_ready) |=> (cur_valid_r && $stable(step_r)))
    else $error("active burst moved while stalled");

endmodule

>>> rtl/core/spi_fram_command_sequencer.sv
// ============================================================================
// spi_fram_command_sequencer: SPI FRAM transaction sequencer
// Turns tick/write/read/done events into FRAM header bytes and chip-select
// changes, with request checks and a per-transfer millisecond timeout.
// ============================================================================
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | in_valid / in_ready        | operation, address, length
//  out     | output    | out_valid / out_ready      | status ... last
//  cfg     | input     | cfg_psel/penable, pready=1 | timeout_ms at offset 0
//
//  An event is decoded and the sequencer state updated in the cycle it is
//  accepted; its 0 to 5 results leave the emitter one per cycle under out_ready.
//  Throughput is set by the single output port: one result per cycle while
//  out_ready is high, so a WRITE header event holds it for five results; a
//  one-deep descriptor slot lets another event be accepted while a burst drains.
//  Reset (rst_n low, synchronous): idle, timer 0, timeout_ms 10, output empty.
//  out_ready low stalls the output; in_ready drops only while the slot is full.
//
module spi_fram_command_sequencer #(
  parameter int unsigned CAPACITY_BYTES = sfcs_pkg::CAPACITY_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [23:0] in_address,
  input  logic [9:0]  in_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_chip_select,
  output logic        out_byte_valid,
  output logic [7:0]  out_spi_byte,
  output logic [8:0]  out_payload_count,
  output logic        out_transaction_done,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned SADDR_W = (CAPACITY_BYTES > 1) ? $clog2(CAPACITY_BYTES) : 1;
  localparam logic [24:0] CAP_LIM = 25'(CAPACITY_BYTES);
  localparam logic [9:0]  MAX_LEN = 10'(sfcs_pkg::MAX_TRANSFER);

  sfcs_pkg::sfcs_phase_t phase_r, phase_nxt;
  logic [SADDR_W-1:0]    saved_addr_r, saved_addr_nxt;
  logic [8:0]            saved_len_r, saved_len_nxt;
  logic [15:0]           elapsed_r, elapsed_nxt;
  logic [15:0]           timeout_r;

  sfcs_pkg::sfcs_burst_t burst;
  logic                  burst_valid;
  logic                  burst_ready;
  logic                  accept;
  logic                  bad_req;
  logic [24:0]           end_addr;
  logic [15:0]           elapsed_inc;
  logic                  cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {16'd0, timeout_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= sfcs_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      timeout_r <= cfg_pwdata[15:0];
    end
  end

  assign in_ready    = burst_ready;
  assign accept      = in_valid && in_ready;
  assign end_addr    = {1'b0, in_address} + {15'd0, in_length};
  assign bad_req     = (in_length == 10'd0) || (in_length > MAX_LEN) || (end_addr > CAP_LIM);
  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;

  always_comb begin
    phase_nxt      = phase_r;
    saved_addr_nxt = saved_addr_r;
    saved_len_nxt  = saved_len_r;
    elapsed_nxt    = elapsed_r;
    burst          = '0;
    burst_valid    = 1'b0;
    burst.hdr_addr = 24'(saved_addr_r);
    burst.hdr_len  = saved_len_r;
    if (accept) begin
      unique case (sfcs_pkg::sfcs_op_t'(in_operation))
        sfcs_pkg::OP_WRITE, sfcs_pkg::OP_READ: begin
          burst_valid   = 1'b1;
          burst.lead_en = 1'b1;
          if (bad_req) begin
            burst.lead_status = sfcs_pkg::ST_BAD_PARAM;
            burst.lead_cs     = (phase_r == sfcs_pkg::PH_IDLE);
          end else if (phase_r != sfcs_pkg::PH_IDLE) begin
            burst.lead_status = sfcs_pkg::ST_BUSY;
          end else begin
            saved_addr_nxt = in_address[SADDR_W-1:0];
            saved_len_nxt  = in_length[8:0];
            elapsed_nxt    = 16'd0;
            if (in_operation == sfcs_pkg::OP_WRITE) begin
              burst.lead_valid = 1'b1;
              burst.lead_byte  = sfcs_pkg::OPC_WREN;
              phase_nxt        = sfcs_pkg::PH_WAIT_WREN;
            end else begin
              burst.lead_en  = 1'b0;
              burst.hdr_en   = 1'b1;
              burst.hdr_cmd  = sfcs_pkg::OPC_READ;
              burst.hdr_addr = in_address;
              burst.hdr_len  = in_length[8:0];
              phase_nxt      = sfcs_pkg::PH_WAIT_READ;
            end
          end
        end
        sfcs_pkg::OP_DONE: begin
          burst.lead_cs = 1'b1;
          if (phase_r == sfcs_pkg::PH_WAIT_WREN) begin
            // release select, then WRITE header
            burst_valid   = 1'b1;
            burst.lead_en = 1'b1;
            burst.hdr_en  = 1'b1;
            burst.hdr_cmd = sfcs_pkg::OPC_WRITE;
            elapsed_nxt   = 16'd0;
            phase_nxt     = sfcs_pkg::PH_WAIT_WRITE;
          end else if (phase_r != sfcs_pkg::PH_IDLE) begin
            burst_valid     = 1'b1;
            burst.lead_en   = 1'b1;
            burst.lead_done = 1'b1;
            phase_nxt       = sfcs_pkg::PH_IDLE;
          end
        end
        sfcs_pkg::OP_TICK: begin
          if (phase_r != sfcs_pkg::PH_IDLE) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc > timeout_r) begin
              burst_valid     = 1'b1;
              burst.lead_en   = 1'b1;
              burst.lead_cs   = 1'b1;
              burst.lead_done = 1'b1;
              unique case (phase_r)
                sfcs_pkg::PH_WAIT_WREN:  burst.lead_status = sfcs_pkg::ST_WREN_TIMEOUT;
                sfcs_pkg::PH_WAIT_WRITE: burst.lead_status = sfcs_pkg::ST_WRITE_TIMEOUT;
                default:                 burst.lead_status = sfcs_pkg::ST_READ_TIMEOUT;
              endcase
              phase_nxt = sfcs_pkg::PH_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= sfcs_pkg::PH_IDLE;
      saved_addr_r <= '0;
      saved_len_r  <= '0;
      elapsed_r    <= '0;
    end else begin
      phase_r      <= phase_nxt;
      saved_addr_r <= saved_addr_nxt;
      saved_len_r  <= saved_len_nxt;
      elapsed_r    <= elapsed_nxt;
    end
  end

  sfcs_emit u_emit (
    .clk                  (clk),
    .rst_n                (rst_n),
    .burst_valid          (burst_valid),
    .burst                (burst),
    .burst_ready          (burst_ready),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_chip_select      (out_chip_select),
    .out_byte_valid       (out_byte_valid),
    .out_spi_byte         (out_spi_byte),
    .out_payload_count    (out_payload_count),
    .out_transaction_done (out_transaction_done),
    .out_last             (out_last)
  );

  // a good request taken while idle always leaves the idle phase
  a_req_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !bad_req && phase_r == sfcs_pkg::PH_IDLE &&
     (in_operation == sfcs_pkg::OP_WRITE || in_operation == sfcs_pkg::OP_READ))
    |=> (phase_r != sfcs_pkg::PH_IDLE && elapsed_r == 16'd0))
    else $error("accepted request did not start a transaction");

  a_idle_timer_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == sfcs_pkg::PH_IDLE && phase_nxt == sfcs_pkg::PH_IDLE)
    |=> $stable(elapsed_r))
    else $error("timer moved while idle");

  a_busy_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && burst.lead_status == sfcs_pkg::ST_BUSY && burst_valid)
    |=> $stable(phase_r))
    else $error("busy reject changed the phase");

endmodule
